@@ src/rud_pkg.sv @@
`timescale 1ns / 1ps

package rud_pkg;

   // microcode address and the places of the program
   typedef logic [1:0] uc_addr_type;

   localparam uc_addr_type UC_LOAD = 2'd0;
   localparam uc_addr_type UC_ITER = 2'd1;
   localparam uc_addr_type UC_EMIT = 2'd2;

   // datapath operation of one control word
   typedef enum logic [1:0] {
      OP_NOP,
      OP_LOAD,
      OP_ITER,
      OP_EMIT
   } uc_op_type;

   // jump condition of one control word; when false the step repeats
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ_VALID,
      COND_COUNT_LAST,
      COND_OUT_FREE
   } uc_cond_type;

   typedef struct packed {
      uc_op_type   op;
      uc_cond_type cond;
      uc_addr_type target;
   } uc_word_type;

   // status fed back to the sequencer
   typedef struct packed {
      logic req_valid;
      logic count_last;
      logic out_free;
   } rud_status_type;

   // control store
   function automatic uc_word_type uc_rom(input uc_addr_type addr);
      uc_word_type word;
      case (addr)
         UC_LOAD: word = '{op: OP_LOAD, cond: COND_REQ_VALID,  target: UC_ITER};
         UC_ITER: word = '{op: OP_ITER, cond: COND_COUNT_LAST, target: UC_EMIT};
         UC_EMIT: word = '{op: OP_EMIT, cond: COND_OUT_FREE,   target: UC_LOAD};
         default: word = '{op: OP_NOP,  cond: COND_ALWAYS,     target: UC_LOAD};
      endcase
      return word;
   endfunction

endpackage

@@ src/rud_seq.sv @@
`timescale 1ns / 1ps

module rud_seq
   import rud_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rud_status_type status,
   output uc_word_type    word
);

   uc_addr_type pc_ff;
   uc_addr_type pc_in;
   logic        cond_true;

   assign word = uc_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_REQ_VALID:  cond_true = status.req_valid;
         COND_COUNT_LAST: cond_true = status.count_last;
         COND_OUT_FREE:   cond_true = status.out_free;
         default:         cond_true = 1'b1;
      endcase
   end

   // jump on condition, otherwise repeat the step
   assign pc_in = cond_true ? word.target : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ src/rud_dpath.sv @@
`timescale 1ns / 1ps

module rud_dpath
   import rud_pkg::*;
#(
   parameter int WIDTH = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  uc_op_type        op,
   input  logic [WIDTH-1:0] num,
   input  logic [WIDTH-1:0] den,
   output logic [WIDTH-1:0] quo,
   output logic [WIDTH-1:0] part,
   output logic             den_zero,
   output logic             count_last
);

   localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] part_ff, part_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic             den_zero_ff, den_zero_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             over;
   logic [WIDTH-1:0] shifted;
   logic [WIDTH:0]   diff;
   logic             take;

   // quo_ff holds the unused dividend bits on top, quotient bits fill from below
   assign over    = part_ff[WIDTH-1];
   assign shifted = {part_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
   assign diff    = {over, shifted} - {1'b0, den_ff};
   assign take    = over | ~diff[WIDTH];

   always_comb begin
      part_in     = part_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      den_zero_in = den_zero_ff;
      cnt_in      = cnt_ff;
      case (op)
         OP_LOAD: begin
            part_in     = '0;
            quo_in      = num;
            den_in      = den;
            den_zero_in = (den == '0);
            cnt_in      = CNT_W'(WIDTH - 1);
         end
         OP_ITER: begin
            part_in = take ? diff[WIDTH-1:0] : shifted;
            quo_in  = {quo_ff[WIDTH-2:0], take};
            cnt_in  = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff     <= part_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
   end

   assign quo        = quo_ff;
   assign part       = part_ff;
   assign den_zero   = den_zero_ff;
   assign count_last = (cnt_ff == '0);

endmodule

@@ src/restoring_unsigned_divider.sv @@
`timescale 1ns / 1ps

// channel | dir | handshake            | payload
// --------+-----+----------------------+------------------------------------------
// req     | in  | req_tvalid/tready    | tdata: dividend[31:0], divisor[63:32]
// rsp     | out | rsp_tvalid/tready    | tdata: quotient[31:0], remainder[63:32]
//         |     |                      | tuser: divide_by_zero
//
// one division runs one load step, WIDTH restoring steps of the shared
// subtractor and one step to hand the result to the output register
// the step count is set by the microcode loop over the single trial subtractor
// synchronous active-high reset returns the sequencer to its load step
// the output register lets the next transaction load while a result waits;
// the finish step holds only while that register is still full

module restoring_unsigned_divider
   import rud_pkg::*;
#(
   parameter int WIDTH = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // dividend [31:0], divisor [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // quotient [31:0], remainder [63:32]
   output logic        rsp_tuser    // divide_by_zero [0]
);

   uc_word_type      word;
   rud_status_type   status;

   logic [WIDTH-1:0] num;
   logic [WIDTH-1:0] den;
   logic [WIDTH-1:0] quo;
   logic [WIDTH-1:0] part;
   logic             den_zero;
   logic             count_last;

   logic [63:0]      num_wide;
   logic [63:0]      den_wide;
   logic [63:0]      quo_wide;
   logic [63:0]      part_wide;

   logic             out_free;
   logic             emit_fire;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_quotient_ff;
   logic [31:0]      rsp_remainder_ff;
   logic             rsp_dbz_ff;

   // operands: only the low WIDTH bits take part
   assign num_wide = 64'(req_tdata[31:0]);
   assign den_wide = 64'(req_tdata[63:32]);
   assign num      = num_wide[WIDTH-1:0];
   assign den      = den_wide[WIDTH-1:0];

   // sequencer status
   assign out_free          = ~rsp_valid_ff | rsp_tready;
   assign status.req_valid  = req_tvalid;
   assign status.count_last = count_last;
   assign status.out_free   = out_free;

   rud_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .word   (word)
   );

   rud_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (word.op),
      .num        (num),
      .den        (den),
      .quo        (quo),
      .part       (part),
      .den_zero   (den_zero),
      .count_last (count_last)
   );

   // input is taken only in the load step, never while in reset
   assign req_tready = (word.op == OP_LOAD) & ~reset;

   // finish step moves the result into the output register once it is free
   assign emit_fire = (word.op == OP_EMIT) & out_free;

   // results keep their low 32 bits
   assign quo_wide  = 64'(quo);
   assign part_wide = 64'(part);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // zero divisor forces quotient and remainder to zero
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_quotient_ff  <= den_zero ? 32'd0 : quo_wide[31:0];
         rsp_remainder_ff <= den_zero ? 32'd0 : part_wide[31:0];
         rsp_dbz_ff       <= den_zero;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_remainder_ff, rsp_quotient_ff};
   assign rsp_tuser  = rsp_dbz_ff;

`ifndef SYNTHESIS
   // a finished division always shows up on the result channel
   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> rsp_tvalid)
      else $error("finished division not presented");

   // a divide-by-zero result carries zero quotient and remainder
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 64'd0))
      else $error("divide-by-zero result not cleared");

   // no second transaction is taken right after one is loaded
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while division in progress");
`endif

endmodule

@@ sim/division_checker.sv @@
`timescale 1ns / 1ps

module division_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // dividend [31:0], divisor [63:32]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // quotient [31:0], remainder [63:32]
   input  logic        rsp_tuser,   // divide_by_zero [0]
   output int          mismatch_count,
   output int          divisions_in_flight
);

   typedef struct packed {
      logic [31:0] quotient;
      logic [31:0] remainder;
      logic        divide_by_zero;
   } division_result_t;

   division_result_t quotients_due [$];
   int failures = 0;

   // bit-serial restoring division, msb of the dividend first
   function automatic division_result_t divide_restoring(input logic [31:0] dividend,
                                                         input logic [31:0] divisor);
      division_result_t result;
      logic [32:0]      partial;
      result  = '0;
      partial = '0;
      if (divisor == '0) begin
         result.divide_by_zero = 1'b1;
         return result;
      end
      for (int step = 31; step >= 0; step--) begin
         partial = {partial[31:0], dividend[step]};
         if (partial >= {1'b0, divisor}) begin
            partial = partial - {1'b0, divisor};
            result.quotient[step] = 1'b1;
         end
      end
      result.remainder = partial[31:0];
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      division_result_t seen;
      division_result_t due;
      if (reset) begin
         quotients_due.delete();
      end else begin
         // results first, so a transaction taken on this edge cannot match
         if (rsp_tvalid && rsp_tready) begin
            seen = '{quotient: rsp_tdata[31:0], remainder: rsp_tdata[63:32],
                     divide_by_zero: rsp_tuser};
            if (quotients_due.size() == 0) begin
               $display("%0t: unexpected result, got quotient %h remainder %h flag %b",
                        $time, seen.quotient, seen.remainder, seen.divide_by_zero);
               failures++;
            end else begin
               due = quotients_due.pop_front();
               if (seen.quotient !== due.quotient) begin
                  $display("%0t: quotient expected %h got %h",
                           $time, due.quotient, seen.quotient);
                  failures++;
               end
               if (seen.remainder !== due.remainder) begin
                  $display("%0t: remainder expected %h got %h",
                           $time, due.remainder, seen.remainder);
                  failures++;
               end
               if (seen.divide_by_zero !== due.divide_by_zero) begin
                  $display("%0t: divide_by_zero expected %b got %b",
                           $time, due.divide_by_zero, seen.divide_by_zero);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            quotients_due.push_back(divide_restoring(req_tdata[31:0], req_tdata[63:32]));
         end
      end
      mismatch_count      <= failures;
      divisions_in_flight <= quotients_due.size();
   end

endmodule

@@ sim/tb_restoring_unsigned_divider.sv @@
`timescale 1ns / 1ps

module tb_restoring_unsigned_divider;

   // stimulus size and timing limits
   localparam int RANDOM_DIVISIONS = 1226;
   localparam int HOLD_START       = 3000;  // receiver cycle count after which the long back-pressure begins
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 40;    // a bit more than one division
   localparam int IDLE_LIMIT       = 2000;  // cycles with no transaction on either side

   typedef enum int {
      RX_STEADY,
      RX_RANDOM,
      RX_PATTERN
   } rx_style_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;     // dividend [31:0], divisor [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // quotient [31:0], remainder [63:32]
   logic        rsp_tuser;           // divide_by_zero [0]

   int mismatch_count;
   int divisions_in_flight;
   int idle_cycles = 0;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   restoring_unsigned_divider u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   division_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .mismatch_count      (mismatch_count),
      .divisions_in_flight (divisions_in_flight)
   );

   // offer one transaction and hold it until the divider takes it;
   // valid is left high so the next call can follow without a bubble
   task automatic send_division(input logic [31:0] dividend, input logic [31:0] divisor);
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      do @(posedge clock); while (!req_tready);
   endtask

   // mix of full-range, shortened, tiny and boundary operands so that
   // quotients of every length show up
   function automatic logic [31:0] random_operand();
      logic [31:0] value;
      case ($urandom_range(0, 3))
         0: value = $urandom;
         1: value = $urandom >> $urandom_range(0, 31);
         2: value = $urandom_range(0, 17);
         default: begin
            if ($urandom_range(0, 1) != 0) value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            else value = 32'h1 << $urandom_range(0, 31);
         end
      endcase
      return value;
   endfunction

   // sender: reset, directed corners, then random bursts with random gaps
   initial begin : stimulus
      logic [31:0] dividend;
      logic [31:0] divisor;
      int          sent;
      int          burst;
      int          gap;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero divisor, with several dividends
      send_division(32'h0000_0000, 32'h0000_0000);
      send_division(32'hFFFF_FFFF, 32'h0000_0000);
      send_division(32'h0000_1234, 32'h0000_0000);
      // divide by one and by the largest divisor
      send_division(32'h0000_0000, 32'h0000_0001);
      send_division(32'hFFFF_FFFF, 32'h0000_0001);
      send_division(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_division(32'h0000_0000, 32'hFFFF_FFFF);
      // dividend below the divisor
      send_division(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_division(32'h7FFF_FFFF, 32'h8000_0000);
      send_division(32'h0000_0007, 32'h0000_0064);
      send_division(32'h0000_0001, 32'h0000_0002);
      // equal operands and msb-heavy divisors
      send_division(32'h8000_0000, 32'h8000_0000);
      send_division(32'h1234_5678, 32'h1234_5678);
      send_division(32'hFFFF_FFFF, 32'h8000_0000);
      send_division(32'hFFFF_FFFF, 32'h8000_0001);
      send_division(32'h8000_0001, 32'h7FFF_FFFF);
      // long quotients
      send_division(32'h8000_0000, 32'h0000_0001);
      send_division(32'hFFFF_FFFF, 32'h0000_0002);
      send_division(32'hDEAD_BEEF, 32'h0000_0003);
      send_division(32'hC000_0000, 32'h0000_0003);
      // alternating bit patterns and mid-size divisors
      send_division(32'hAAAA_AAAA, 32'h5555_5555);
      send_division(32'h5555_5555, 32'hAAAA_AAAA);
      send_division(32'hFFFF_FFFF, 32'h0001_0000);
      send_division(32'hFFFF_FFFF, 32'h0000_FFFF);
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clock);

      sent = 0;
      while (sent < RANDOM_DIVISIONS) begin
         burst = $urandom_range(1, 12);
         for (int n = 0; n < burst && sent < RANDOM_DIVISIONS; n++) begin
            divisor  = ($urandom_range(0, 11) == 0) ? 32'h0 : random_operand();
            dividend = ($urandom_range(0, 15) == 0) ? divisor : random_operand();
            send_division(dividend, divisor);
            sent++;
         end
         // some bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 40);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // let the checker see the last transaction, then drain
      repeat (2) @(posedge clock);
      while (divisions_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // receiver: stretches of steady, random and patterned ready, plus one
   // long hold-off that fills the output register and stalls the input
   initial begin : receiver
      rx_style_t style;
      int        stretch;
      int        cycles_run;
      bit        hold_done;

      cycles_run = 0;
      hold_done  = 1'b0;
      forever begin
         if (!hold_done && cycles_run >= HOLD_START) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycles_run += HOLD_CYCLES;
         end
         style   = rx_style_t'($urandom_range(0, 2));
         stretch = $urandom_range(8, 150);
         for (int n = 0; n < stretch; n++) begin
            case (style)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
               default:   rsp_tready <= ((n % 4) != 3);
            endcase
            @(posedge clock);
         end
         cycles_run += stretch;
      end
   end

   // watchdog: ends a run that stops moving transactions
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
